>>> rtl/core/ppsp_pkg.sv
// Shared types and constants of the P6 image stream parser.
package ppsp_pkg;

	localparam logic [2:0] ST_OK             = 3'd0;
	localparam logic [2:0] ST_NO_MAGIC       = 3'd1;
	localparam logic [2:0] ST_BAD_MAGIC      = 3'd2;
	localparam logic [2:0] ST_BAD_WIDTH      = 3'd3;
	localparam logic [2:0] ST_BAD_HEIGHT     = 3'd4;
	localparam logic [2:0] ST_BAD_MAXVAL     = 3'd5;
	localparam logic [2:0] ST_MAXVAL_NOT_255 = 3'd6;
	localparam logic [2:0] ST_INCOMPLETE     = 3'd7;

	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_SIX   = 8'h36;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef struct packed {
		logic [7:0] data;
		logic       present;
		logic       eof;
		logic       is_space;
		logic       is_hash;
		logic       is_lf;
		logic       is_digit;
		logic       is_plus;
		logic       is_p;
		logic       is_six;
	} byte_class_t;

endpackage

>>> rtl/core/ppsp_front.sv
// Front end: classifies incoming bytes and holds them in a two-entry queue.
module ppsp_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  logic [7:0]           data_byte,
	input  logic                 byte_present,
	input  logic                 end_of_file,
	output logic                 head_valid,
	output ppsp_pkg::byte_class_t head,
	input  logic                 pop
);

	ppsp_pkg::byte_class_t mem_q [2];
	ppsp_pkg::byte_class_t cls;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       do_pop;

	always_comb begin
		cls.data     = data_byte;
		cls.present  = byte_present;
		cls.eof      = end_of_file;
		cls.is_space = (data_byte == ppsp_pkg::CH_SPACE) ||
			((data_byte >= ppsp_pkg::CH_TAB) && (data_byte <= ppsp_pkg::CH_CR));
		cls.is_hash  = data_byte == ppsp_pkg::CH_HASH;
		cls.is_lf    = data_byte == ppsp_pkg::CH_LF;
		cls.is_digit = (data_byte >= ppsp_pkg::CH_ZERO) && (data_byte <= ppsp_pkg::CH_NINE);
		cls.is_plus  = data_byte == ppsp_pkg::CH_PLUS;
		cls.is_p     = data_byte == ppsp_pkg::CH_P;
		cls.is_six   = data_byte == ppsp_pkg::CH_SIX;
	end

	assign item_stall = cnt_q == 2'd2;
	assign push       = item_valid && !item_stall;
	assign head_valid = cnt_q != 2'd0;
	assign head       = mem_q[rd_ptr_q];
	assign do_pop     = head_valid && pop;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, do_pop};
		end
	end

endmodule

>>> rtl/core/ppsp_back.sv
// Back end: header state machine, pixel counter and result register.
module ppsp_back #(
	parameter int DIM_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  head_valid,
	input  ppsp_pkg::byte_class_t head,
	output logic                  pop,
	output logic                  res_valid,
	input  logic                  res_stall,
	output logic                  pixel_valid,
	output logic [7:0]            pixel_byte,
	output logic                  done_res,
	output logic [2:0]            status,
	output logic [15:0]           image_width,
	output logic [15:0]           image_height
);

	localparam int LW = 2 * DIM_BITS;
	localparam logic [DIM_BITS-1:0] LIMIT = {DIM_BITS{1'b1}};

	typedef enum logic [2:0] {PH_MAGIC, PH_WIDTH, PH_HEIGHT, PH_MAXVAL, PH_PIXELS} phase_t;

	typedef struct packed {
		phase_t     phase;
		logic       rep;
		logic [2:0] st;
		logic       set_w;
		logic       set_h;
		logic       start;
	} endtok_t;

	function automatic endtok_t end_tok(input phase_t ph, input logic inv,
		input logic [2:0] idx, input logic num_ok, input logic is255);
		endtok_t e;
		e = '{phase: ph, rep: 1'b0, st: ppsp_pkg::ST_OK, set_w: 1'b0, set_h: 1'b0,
			start: 1'b0};
		case (ph)
			PH_MAGIC: begin
				if (!inv && idx == 3'd2) e.phase = PH_WIDTH;
				else begin e.rep = 1'b1; e.st = ppsp_pkg::ST_BAD_MAGIC; end
			end
			PH_WIDTH: begin
				if (num_ok) begin e.phase = PH_HEIGHT; e.set_w = 1'b1; end
				else begin e.rep = 1'b1; e.st = ppsp_pkg::ST_BAD_WIDTH; end
			end
			PH_HEIGHT: begin
				if (num_ok) begin e.phase = PH_MAXVAL; e.set_h = 1'b1; end
				else begin e.rep = 1'b1; e.st = ppsp_pkg::ST_BAD_HEIGHT; end
			end
			default: begin
				if (!num_ok) begin e.rep = 1'b1; e.st = ppsp_pkg::ST_BAD_MAXVAL; end
				else if (!is255) begin
					e.rep = 1'b1;
					e.st  = ppsp_pkg::ST_MAXVAL_NOT_255;
				end else begin
					e.phase = PH_PIXELS;
					e.start = 1'b1;
				end
			end
		endcase
		return e;
	endfunction

	phase_t              phase_q, n_phase;
	logic                comment_q, n_comment;
	logic                tok_q, n_tok;
	logic [2:0]          idx_q, n_idx;
	logic                inv_q, n_inv;
	logic [DIM_BITS-1:0] num_q, n_num;
	logic [DIM_BITS-1:0] width_q, n_width;
	logic [DIM_BITS-1:0] height_q, n_height;
	logic [LW-1:0]       left_q, n_left;
	logic [1:0]          bip_q, n_bip;
	logic                fin_q, n_fin;

	logic                res_valid_q;
	logic                pixel_valid_q;
	logic [7:0]          pixel_byte_q;
	logic                done_q;
	logic [2:0]          status_q;
	logic [15:0]         width_out_q;
	logic [15:0]         height_out_q;

	logic                r_any, r_pv, r_done;
	logic [7:0]          r_pb;
	logic [2:0]          r_st;
	logic [15:0]         r_w, r_h;
	logic [LW-1:0]       product;
	logic [DIM_BITS+15:0] wext, hext;

	assign pop     = !res_valid_q || !res_stall;
	assign product = LW'(width_q) * LW'(height_q);
	assign wext    = {16'b0, width_q};
	assign hext    = {16'b0, height_q};

	always_comb begin
		endtok_t             e;
		logic [DIM_BITS+3:0] acc;
		n_phase = phase_q; n_comment = comment_q; n_tok = tok_q; n_idx = idx_q;
		n_inv = inv_q; n_num = num_q; n_width = width_q; n_height = height_q;
		n_left = left_q; n_bip = bip_q; n_fin = fin_q;
		r_any = 1'b0; r_pv = 1'b0; r_pb = 8'd0; r_done = 1'b0;
		r_st = ppsp_pkg::ST_OK; r_w = 16'd0; r_h = 16'd0;
		e = '0;
		acc = '0;

		if (head.present && !fin_q) begin
			if (comment_q) begin
				if (head.is_lf) n_comment = 1'b0;
			end else if (phase_q == PH_PIXELS) begin
				r_any = 1'b1;
				r_pv  = 1'b1;
				r_pb  = head.data;
				if (bip_q == 2'd2) begin
					n_bip  = 2'd0;
					n_left = (left_q == '0) ? '0 : left_q - LW'(1);
					if (left_q[LW-1:1] == '0) begin
						r_done = 1'b1;
						r_w    = wext[15:0];
						r_h    = hext[15:0];
						n_fin  = 1'b1;
					end
				end else begin
					n_bip = bip_q + 2'd1;
				end
			end else if (head.is_space || head.is_hash) begin
				if (head.is_hash) n_comment = 1'b1;
				if (tok_q) begin
					n_tok = 1'b0;
					e = end_tok(phase_q, inv_q, idx_q, !inv_q && num_q != '0,
						num_q == DIM_BITS'(255));
				end
			end else begin
				// A token character; the first one opens a fresh token.
				if (!tok_q) begin
					n_tok = 1'b1;
					n_idx = 3'd0;
					n_inv = 1'b0;
					n_num = '0;
				end
				if (phase_q == PH_MAGIC) begin
					if (!((n_idx == 3'd0 && head.is_p) || (n_idx == 3'd1 && head.is_six)))
						n_inv = 1'b1;
				end else if (head.is_digit) begin
					acc = ({4'b0, n_num} << 3) + ({4'b0, n_num} << 1) +
						{{DIM_BITS{1'b0}}, head.data[3:0]};
					if (acc > {4'b0, LIMIT}) begin
						n_inv = 1'b1;
						n_num = LIMIT;
					end else begin
						n_num = acc[DIM_BITS-1:0];
					end
				end else if (!(head.is_plus && n_idx == 3'd0)) begin
					n_inv = 1'b1;
				end
				if (n_idx != 3'd7) n_idx = n_idx + 3'd1;
			end
		end

		if (head.eof && !n_fin && n_tok && n_phase != PH_PIXELS && !e.rep) begin
			n_tok = 1'b0;
			e = end_tok(n_phase, n_inv, n_idx, !n_inv && n_num != '0,
				n_num == DIM_BITS'(255));
		end

		if (e.rep) begin
			r_any = 1'b1; r_done = 1'b1; r_st = e.st; r_w = 16'd0; r_h = 16'd0;
			n_fin = 1'b1;
		end else begin
			n_phase = e.phase == PH_MAGIC && n_phase != PH_MAGIC ? n_phase : e.phase;
		end
		if (e.set_w) n_width = n_num;
		if (e.set_h) n_height = n_num;
		if (e.start) begin
			n_left = product;
			n_bip  = 2'd0;
		end

		if (head.eof) begin
			if (!n_fin) begin
				r_any = 1'b1; r_done = 1'b1; r_w = 16'd0; r_h = 16'd0;
				case (n_phase)
					PH_MAGIC:  r_st = ppsp_pkg::ST_NO_MAGIC;
					PH_WIDTH:  r_st = ppsp_pkg::ST_BAD_WIDTH;
					PH_HEIGHT: r_st = ppsp_pkg::ST_BAD_HEIGHT;
					PH_MAXVAL: r_st = ppsp_pkg::ST_BAD_MAXVAL;
					default:   r_st = ppsp_pkg::ST_INCOMPLETE;
				endcase
			end
			n_phase = PH_MAGIC; n_comment = 1'b0; n_tok = 1'b0; n_idx = 3'd0;
			n_inv = 1'b0; n_num = '0; n_width = '0; n_height = '0;
			n_left = '0; n_bip = 2'd0; n_fin = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MAGIC; comment_q <= 1'b0; tok_q <= 1'b0; idx_q <= 3'd0;
			inv_q <= 1'b0; num_q <= '0; width_q <= '0; height_q <= '0;
			left_q <= '0; bip_q <= 2'd0; fin_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (head_valid && pop) begin
			phase_q <= n_phase; comment_q <= n_comment; tok_q <= n_tok; idx_q <= n_idx;
			inv_q <= n_inv; num_q <= n_num; width_q <= n_width; height_q <= n_height;
			left_q <= n_left; bip_q <= n_bip; fin_q <= n_fin;
			res_valid_q <= r_any;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (head_valid && pop) begin
			pixel_valid_q <= r_pv;
			pixel_byte_q  <= r_pb;
			done_q        <= r_done;
			status_q      <= r_st;
			width_out_q   <= r_w;
			height_out_q  <= r_h;
		end
	end

	assign res_valid    = res_valid_q;
	assign pixel_valid  = pixel_valid_q;
	assign pixel_byte   = pixel_byte_q;
	assign done_res     = done_q;
	assign status       = status_q;
	assign image_width  = width_out_q;
	assign image_height = height_out_q;

endmodule

>>> rtl/core/ppm_p6_stream_parser_unit.sv
// Top level of the P6 image stream parser.
// The item channel (item_valid, item_stall) carries one file byte per transfer:
// data_byte, with byte_present marking it valid and end_of_file closing the file.
// The result channel (res_valid, res_stall) carries at most one result per item:
// a pixel byte, a final status with the image size, or both at once.
// Items with no result, such as header bytes, produce no result transfer.
// An item passes through the input queue and then through the header/pixel
// logic into the result register. Throughput is one item per cycle while
// res_stall is low, limited by the single state update per byte in the
// back end. When res_stall is high a pending result holds; the two-entry
// queue keeps taking items until it fills, then item_stall rises.
// Reset clears the queue, the result register and the parser state, so the
// next byte is taken as the start of a new file. End of file clears the
// parser state likewise after its item is processed. Image width and height
// are parsed with up to DIM_BITS bits; larger values are reported as invalid.
module ppm_p6_stream_parser_unit #(
	parameter int DIM_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [7:0]  data_byte,
	input  logic        byte_present,
	input  logic        end_of_file,
	output logic        res_valid,
	input  logic        res_stall,
	output logic        pixel_valid,
	output logic [7:0]  pixel_byte,
	output logic        done_res,
	output logic [2:0]  status,
	output logic [15:0] image_width,
	output logic [15:0] image_height
);

	ppsp_pkg::byte_class_t head;
	logic                  head_valid;
	logic                  pop;

	ppsp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.data_byte    (data_byte),
		.byte_present (byte_present),
		.end_of_file  (end_of_file),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop)
	);

	ppsp_back #(.DIM_BITS(DIM_BITS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.pixel_valid  (pixel_valid),
		.pixel_byte   (pixel_byte),
		.done_res     (done_res),
		.status       (status),
		.image_width  (image_width),
		.image_height (image_height)
	);

`ifndef SYNTHESIS
	a_err_no_size: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && done_res && status != ppsp_pkg::ST_OK |->
		image_width == 16'd0 && image_height == 16'd0)
		else $error("error result carries image size");
	a_bare_is_final: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !pixel_valid |-> done_res && pixel_byte == 8'd0)
		else $error("result without pixel is not a final status");
	a_pixel_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !done_res |-> status == ppsp_pkg::ST_OK)
		else $error("status set on a non-final result");
`endif

endmodule

>>> bench/ppm_p6_stream_parser_unit_tb.sv
// Self-checking testbench of the P6 image stream parser with randomized handshakes.
`timescale 1ns / 100ps

module ppm_p6_stream_parser_unit_tb;

	typedef struct packed {
		logic [7:0] data;
		logic       present;
		logic       eof;
	} file_item_t;

	typedef struct packed {
		logic        pv;
		logic [7:0]  pb;
		logic        done;
		logic [2:0]  st;
		logic [15:0] w;
		logic [15:0] h;
	} parse_result_t;

	localparam int DIMB = 16;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef enum logic [2:0] {
		PH_MAGIC, PH_WIDTH, PH_HEIGHT, PH_MAXVAL, PH_PIXELS
	} phase_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic [7:0]  data_byte = 8'd0;
	logic        byte_present = 1'b0;
	logic        end_of_file = 1'b0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic        pixel_valid;
	logic [7:0]  pixel_byte;
	logic        done_res;
	logic [2:0]  status;
	logic [15:0] image_width;
	logic [15:0] image_height;

	ppm_p6_stream_parser_unit #(.DIM_BITS(DIMB)) DUT (.*);

	always #5 clk = ~clk;

	file_item_t    pending_items[$];
	parse_result_t expected_results[$];
	int  error_count = 0;
	int  items_sent = 0;
	int  results_seen = 0;
	int  files_done = 0;
	int  idle_send_pct = 0;
	int  idle_recv_pct = 0;
	bit  hold_off = 1'b0;
	int  quiet_cycles = 0;
	bit  took_item = 1'b0;

	// Parser state of the prediction.
	phase_t      ph;
	bit          in_comment, in_token, tok_bad, finished;
	int unsigned tok_idx;
	longint unsigned tok_num, wd, ht, px_left;
	int unsigned byte_idx;

	function automatic void clear_parser();
		ph = PH_MAGIC;
		in_comment = 0; in_token = 0; tok_bad = 0; finished = 0;
		tok_idx = 0; tok_num = 0; wd = 0; ht = 0; px_left = 0; byte_idx = 0;
	endfunction

	function automatic void flag_status(ref parse_result_t r, ref bit any,
		input logic [2:0] st);
		any = 1; r.done = 1; r.st = st; r.w = '0; r.h = '0;
		finished = 1;
	endfunction

	function automatic void close_token(ref parse_result_t r, ref bit any);
		bit ok;
		ok = !tok_bad && tok_num > 0;
		in_token = 0;
		case (ph)
			PH_MAGIC: begin
				if (!tok_bad && tok_idx == 2) ph = PH_WIDTH;
				else flag_status(r, any, ppsp_pkg::ST_BAD_MAGIC);
			end
			PH_WIDTH: begin
				if (ok) begin wd = tok_num; ph = PH_HEIGHT; end
				else flag_status(r, any, ppsp_pkg::ST_BAD_WIDTH);
			end
			PH_HEIGHT: begin
				if (ok) begin ht = tok_num; ph = PH_MAXVAL; end
				else flag_status(r, any, ppsp_pkg::ST_BAD_HEIGHT);
			end
			default: begin
				if (!ok) flag_status(r, any, ppsp_pkg::ST_BAD_MAXVAL);
				else if (tok_num != 255) flag_status(r, any, ppsp_pkg::ST_MAXVAL_NOT_255);
				else begin
					ph = PH_PIXELS; px_left = wd * ht; byte_idx = 0;
				end
			end
		endcase
	endfunction

	function automatic void add_token_char(logic [7:0] c);
		longint unsigned lim;
		lim = (64'd1 << DIMB) - 1;
		if (!in_token) begin
			in_token = 1; tok_idx = 0; tok_bad = 0; tok_num = 0;
		end
		if (ph == PH_MAGIC) begin
			if (!((tok_idx == 0 && c == ppsp_pkg::CH_P) ||
				(tok_idx == 1 && c == ppsp_pkg::CH_SIX)))
				tok_bad = 1;
		end else if (c >= ppsp_pkg::CH_ZERO && c <= ppsp_pkg::CH_NINE) begin
			tok_num = tok_num * 10 + (c - ppsp_pkg::CH_ZERO);
			if (tok_num > lim) begin tok_bad = 1; tok_num = lim; end
		end else if (!(c == ppsp_pkg::CH_PLUS && tok_idx == 0)) begin
			tok_bad = 1;
		end
		if (tok_idx < 7) tok_idx++;
	endfunction

	function automatic void predict_parse(file_item_t it);
		parse_result_t r;
		bit any;
		logic [7:0] c;
		r = '0; any = 0; c = it.data;
		if (it.present && !finished) begin
			if (in_comment) begin
				if (c == ppsp_pkg::CH_LF) in_comment = 0;
			end else if (ph == PH_PIXELS) begin
				any = 1; r.pv = 1; r.pb = c;
				byte_idx++;
				if (byte_idx >= 3) begin
					byte_idx = 0;
					if (px_left > 0) px_left--;
					if (px_left == 0) begin
						r.done = 1; r.st = ppsp_pkg::ST_OK; r.w = wd[15:0]; r.h = ht[15:0];
						finished = 1;
					end
				end
			end else if (c == ppsp_pkg::CH_SPACE ||
				(c >= ppsp_pkg::CH_TAB && c <= ppsp_pkg::CH_CR)) begin
				if (in_token) close_token(r, any);
			end else if (c == ppsp_pkg::CH_HASH) begin
				in_comment = 1;
				if (in_token) close_token(r, any);
			end else begin
				add_token_char(c);
			end
		end
		if (it.eof) begin
			if (!finished && in_token && ph != PH_PIXELS) close_token(r, any);
			if (!finished) begin
				case (ph)
					PH_MAGIC:  flag_status(r, any, ppsp_pkg::ST_NO_MAGIC);
					PH_WIDTH:  flag_status(r, any, ppsp_pkg::ST_BAD_WIDTH);
					PH_HEIGHT: flag_status(r, any, ppsp_pkg::ST_BAD_HEIGHT);
					PH_MAXVAL: flag_status(r, any, ppsp_pkg::ST_BAD_MAXVAL);
					default:   flag_status(r, any, ppsp_pkg::ST_INCOMPLETE);
				endcase
			end
			clear_parser();
		end
		if (any) expected_results.insert(expected_results.size(), r);
	endfunction

	// Remembers whether the item on offer was taken at the last rising edge.
	always @(posedge clk) begin
		took_item <= arst_n && item_valid && !item_stall;
	end

	// Driver: offers the next pending item at the falling edge.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!item_valid || took_item) begin
				if (pending_items.size() > 0 && $urandom_range(99) >= idle_send_pct) begin
					item_valid   <= 1'b1;
					data_byte    <= pending_items[0].data;
					byte_present <= pending_items[0].present;
					end_of_file  <= pending_items[0].eof;
					void'(pending_items.pop_front());
				end else begin
					item_valid <= 1'b0;
				end
			end
			res_stall <= hold_off || ($urandom_range(99) < idle_recv_pct);
		end
	end

	// Monitor: predicts on each item transfer and checks each result transfer.
	always @(posedge clk) begin
		parse_result_t e;
		if (arst_n) begin
			if ((item_valid && !item_stall) || (res_valid && !res_stall)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (item_valid && !item_stall) begin
				predict_parse('{data_byte, byte_present, end_of_file});
				items_sent <= items_sent + 1;
			end
			if (res_valid && !res_stall) begin
				results_seen <= results_seen + 1;
				if (expected_results.size() == 0) begin
					$error("unexpected result transfer");
					error_count++;
				end else begin
					e = expected_results.pop_front();
					if (done_res) files_done <= files_done + 1;
					if (pixel_valid !== e.pv) begin
						$error("pixel_valid exp %0d got %0d", e.pv, pixel_valid); error_count++;
					end
					if (pixel_byte !== e.pb) begin
						$error("pixel_byte exp %0h got %0h", e.pb, pixel_byte); error_count++;
					end
					if (done_res !== e.done) begin
						$error("done_res exp %0d got %0d", e.done, done_res); error_count++;
					end
					if (status !== e.st) begin
						$error("status exp %0d got %0d", e.st, status); error_count++;
					end
					if (image_width !== e.w) begin
						$error("image_width exp %0d got %0d", e.w, image_width); error_count++;
					end
					if (image_height !== e.h) begin
						$error("image_height exp %0d got %0d", e.h, image_height); error_count++;
					end
				end
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	task automatic queue_item(file_item_t it);
		pending_items.insert(pending_items.size(), it);
	endtask

	task automatic push_byte(logic [7:0] b, bit eof = 0);
		queue_item('{b, 1'b1, eof});
	endtask

	task automatic push_text(string s);
		for (int i = 0; i < s.len(); i++) push_byte(s[i]);
	endtask

	function automatic logic [7:0] pick_space();
		case ($urandom_range(5))
			0: return ppsp_pkg::CH_SPACE;
			1: return ppsp_pkg::CH_TAB;
			2: return ppsp_pkg::CH_LF;
			3: return 8'h0B;
			4: return 8'h0C;
			default: return ppsp_pkg::CH_CR;
		endcase
	endfunction

	// A mostly well-formed file with random content and an occasional defect.
	task automatic push_random_file();
		int w, h, n, flaw;
		string num;
		w = $urandom_range(1, 4); h = $urandom_range(1, 3);
		flaw = $urandom_range(9);
		push_text(flaw == 0 ? "P5" : "P6");
		push_byte(pick_space());
		if ($urandom_range(3) == 0) push_text("# note\n");
		if ($urandom_range(4) == 0) push_byte(ppsp_pkg::CH_PLUS);
		num.itoa(flaw == 1 ? 0 : w); push_text(num);
		push_byte(pick_space());
		num.itoa(flaw == 2 ? 70000 : h); push_text(num);
		if (flaw == 3) push_byte(8'h2D);
		push_byte($urandom_range(1) ? pick_space() : ppsp_pkg::CH_HASH);
		if (pending_items[$].data == ppsp_pkg::CH_HASH) push_text("x\n");
		num.itoa(flaw == 4 ? $urandom_range(1, 254) : 255); push_text(num);
		push_byte(pick_space());
		n = w * h * 3;
		if (flaw == 5) n = $urandom_range(n - 1);
		if (flaw == 6) n = n + $urandom_range(1, 3);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(15) == 0) queue_item('{8'($urandom), 1'b0, 1'b0});
			push_byte(8'($urandom));
		end
		if ($urandom_range(1)) queue_item('{8'($urandom), 1'b0, 1'b1});
		else pending_items[$].eof = 1'b1;
	endtask

	task automatic wait_drained();
		while (pending_items.size() > 0 || item_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	initial begin
		clear_parser();
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Directed files: a good one with comment and plus sign, then the error cases.
		push_text("P6 #c\n+2\t1\r255 ");
		for (int i = 0; i < 6; i++) push_byte(i == 0 ? 8'hFF : 8'h00);
		push_byte(8'h55, 1);
		queue_item('{8'hAA, 1'b0, 1'b1});
		push_text("Q6 "); push_byte(ppsp_pkg::CH_SPACE, 1);
		push_text("P6 -3"); push_byte(ppsp_pkg::CH_SPACE, 1);
		push_text("P6 1 99999 "); push_byte(ppsp_pkg::CH_SPACE, 1);
		push_text("P6 1 1 65536#"); push_byte(ppsp_pkg::CH_LF, 1);
		push_text("P6 1 1 15 "); push_byte(ppsp_pkg::CH_SPACE, 1);
		push_text("P6 1 1 255 12"); push_byte(8'h7F, 1);
		push_text("P6 1 1 25"); push_byte(8'h35, 1);
		wait_drained();

		// Long receiver hold-off while the sender keeps offering.
		hold_off = 1'b1;
		push_random_file();
		repeat (60) @(posedge clk);
		hold_off = 1'b0;
		wait_drained();

		for (int phase = 0; phase < 4; phase++) begin
			idle_send_pct = (phase == 1 || phase == 3) ? (phase == 1 ? 77 : 34) : 0;
			idle_recv_pct = (phase == 2 || phase == 3) ? (phase == 2 ? 77 : 34) : 0;
			while (items_sent + pending_items.size() < 100 + 360 * (phase + 1))
				push_random_file();
			wait_drained();
		end

		$display("Sent %0d items over %0d files, checked %0d results.",
			items_sent, files_done, results_seen);
		$display("Phases covered idle-free, sender gaps, receiver stalls and both.");
		if (error_count == 0 && expected_results.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
